// ----- hw/rtl/iolt_pkg.sv -----
package iolt_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int NUM_TYPES   = 5;

  localparam int SLOT_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int TYPE_AW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int TYPE_W  = 3;
  localparam int TIME_W  = 64;
  localparam int CNT_W   = 32;

  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_END   = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [TIME_W-1:0] stamp;
  } slot_entry_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] sum_ns;
    logic [TIME_W-1:0] max_ns;
  } stat_t;

  function automatic logic type_ok(input logic [TYPE_W-1:0] t);
    return (t != '0) && (32'(t) <= NUM_TYPES);
  endfunction

  function automatic logic [DEPTH_W-1:0] top_depth(input logic [STACK_DEPTH-1:0] occ);
    logic [DEPTH_W-1:0] d;
    d = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (occ[i]) begin
        d = DEPTH_W'(i + 1);
      end
    end
    return d;
  endfunction

endpackage

// ----- hw/rtl/iolt_if.sv -----
interface iolt_req_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [iolt_pkg::TYPE_W-1:0]       op_type;
  logic                              slot_valid;
  logic [3:0]                        slot;
  logic [iolt_pkg::TIME_W-1:0]       start_stamp;
  logic [iolt_pkg::TIME_W-1:0]       now_ns;

  modport source (output valid, func, op_type, slot_valid, slot, start_stamp, now_ns,
                  input ready);
  modport sink (input valid, func, op_type, slot_valid, slot, start_stamp, now_ns,
                output ready);
endinterface

interface iolt_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [iolt_pkg::TYPE_W-1:0]       token_type;
  logic                              token_slot_valid;
  logic [3:0]                        token_slot;
  logic [iolt_pkg::TYPE_W-1:0]       current_type;
  logic [iolt_pkg::TIME_W-1:0]       current_start_ns;
  logic [4:0]                        stack_depth;
  logic [iolt_pkg::CNT_W-1:0]        overflow_count;
  logic [iolt_pkg::CNT_W-1:0]        stat_count;
  logic [iolt_pkg::TIME_W-1:0]       stat_total_ns;
  logic [iolt_pkg::TIME_W-1:0]       stat_max_ns;

  modport source (output valid, token_type, token_slot_valid, token_slot, current_type,
                  current_start_ns, stack_depth, overflow_count, stat_count,
                  stat_total_ns, stat_max_ns,
                  input ready);
  modport sink (input valid, token_type, token_slot_valid, token_slot, current_type,
                current_start_ns, stack_depth, overflow_count, stat_count,
                stat_total_ns, stat_max_ns,
                output ready);
endinterface

// ----- hw/rtl/iolt_ram.sv -----
module iolt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/iolt_stat_upd.sv -----
module iolt_stat_upd (
  input  iolt_pkg::stat_t                  old_stat,
  input  logic [iolt_pkg::TIME_W-1:0]      elapsed,
  output iolt_pkg::stat_t                  new_stat
);

  logic [iolt_pkg::TIME_W:0] sum;

  assign sum = {1'b0, old_stat.sum_ns} + {1'b0, elapsed};

  always_comb begin
    new_stat.count    = (&old_stat.count) ? old_stat.count : old_stat.count + 1'b1;
    new_stat.sum_ns   = sum[iolt_pkg::TIME_W] ? '1 : sum[iolt_pkg::TIME_W-1:0];
    new_stat.max_ns   = (elapsed > old_stat.max_ns) ? elapsed : old_stat.max_ns;
  end

endmodule

// ----- hw/rtl/inflight_op_latency_tracker.sv -----
// Channel  Role    Carries
// req      sink    func, op_type, slot_valid, slot, start_stamp, now_ns
// rsp      source  token, innermost slot, depth, overflow, per-type stats
//
// Per request, the accept cycle updates the occupancy bits, trims the stack and
// reads the slot memory and, for a valid type, the statistics memory; ST_UPDATE
// then does the statistics read-modify-write and loads the response register.
// Reset clears control, occupancy, depth, overflow and the per-type valid bits.
// A response held by the sink stalls the update cycle; req.ready is high in idle.
module inflight_op_latency_tracker (
  input logic         clk,
  input logic         rst,
  iolt_req_if.sink    req,
  iolt_rsp_if.source  rsp
);

  iolt_pkg::state_t state, state_next;

  logic [iolt_pkg::STACK_DEPTH-1:0] occ, occ_next;
  logic [iolt_pkg::DEPTH_W-1:0]     depth, depth_next;
  logic [iolt_pkg::CNT_W-1:0]       overflow;
  logic [iolt_pkg::NUM_TYPES-1:0]   stat_vld;

  logic                             l_func;
  logic [iolt_pkg::TYPE_W-1:0]      l_type;
  logic                             l_valid;
  logic                             l_push;
  logic [3:0]                       l_tok_slot;
  logic [iolt_pkg::TIME_W-1:0]      l_now;
  logic [iolt_pkg::TIME_W-1:0]      elapsed;

  logic                             req_ready;
  logic                             accept;
  logic                             load;
  logic                             in_valid;
  logic                             push;
  logic                             full;
  logic                             free_slot;
  logic [iolt_pkg::TYPE_AW-1:0]     req_ti;
  logic [iolt_pkg::TYPE_AW-1:0]     l_ti;
  logic [iolt_pkg::SLOT_W-1:0]      slot_raddr;

  iolt_pkg::slot_entry_t            slot_wdata;
  iolt_pkg::slot_entry_t            slot_rdata;
  logic [$bits(iolt_pkg::slot_entry_t)-1:0] slot_rbits;
  logic [$bits(iolt_pkg::stat_t)-1:0]       stat_rbits;
  iolt_pkg::stat_t                  stat_old;
  iolt_pkg::stat_t                  stat_new;
  logic                             stat_we;

  logic                             o_valid;
  logic [iolt_pkg::TYPE_W-1:0]      o_token_type;
  logic                             o_token_slot_valid;
  logic [3:0]                       o_token_slot;
  logic [iolt_pkg::TYPE_W-1:0]      o_current_type;
  logic [iolt_pkg::TIME_W-1:0]      o_current_start_ns;
  logic [4:0]                       o_stack_depth;
  logic [iolt_pkg::CNT_W-1:0]       o_overflow_count;
  logic [iolt_pkg::CNT_W-1:0]       o_stat_count;
  logic [iolt_pkg::TIME_W-1:0]      o_stat_total_ns;
  logic [iolt_pkg::TIME_W-1:0]      o_stat_max_ns;

  assign accept   = req.valid && req_ready;
  assign in_valid = iolt_pkg::type_ok(req.op_type);
  assign full     = (32'(depth) >= iolt_pkg::STACK_DEPTH);
  assign push     = (req.func == iolt_pkg::FUNC_BEGIN) && in_valid && !full;
  assign free_slot = (req.func == iolt_pkg::FUNC_END) && in_valid && req.slot_valid &&
                     (32'(req.slot) < iolt_pkg::STACK_DEPTH);
  assign req_ti   = iolt_pkg::TYPE_AW'(req.op_type - 1'b1);
  assign l_ti     = iolt_pkg::TYPE_AW'(l_type - 1'b1);

  always_comb begin
    occ_next = occ;
    if (push) begin
      occ_next[depth[iolt_pkg::SLOT_W-1:0]] = 1'b1;
    end
    if (free_slot) begin
      occ_next[req.slot[iolt_pkg::SLOT_W-1:0]] = 1'b0;
    end
    depth_next = iolt_pkg::top_depth(occ_next);
    slot_raddr = (depth_next == '0) ? '0 :
                 iolt_pkg::SLOT_W'(depth_next - 1'b1);
  end

  always_comb begin
    slot_wdata.kind  = req.op_type;
    slot_wdata.stamp = req.now_ns;
  end

  iolt_ram #(
    .DEPTH (iolt_pkg::STACK_DEPTH),
    .WIDTH ($bits(iolt_pkg::slot_entry_t))
  ) u_slot_ram (
    .clk   (clk),
    .we    (accept && push),
    .waddr (depth[iolt_pkg::SLOT_W-1:0]),
    .wdata (slot_wdata),
    .re    (accept),
    .raddr (slot_raddr),
    .rdata (slot_rbits)
  );

  assign slot_rdata = iolt_pkg::slot_entry_t'(slot_rbits);

  iolt_ram #(
    .DEPTH (iolt_pkg::NUM_TYPES),
    .WIDTH ($bits(iolt_pkg::stat_t))
  ) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (l_ti),
    .wdata (stat_new),
    .re    (accept && in_valid),
    .raddr (req_ti),
    .rdata (stat_rbits)
  );

  assign stat_old = (l_valid && stat_vld[l_ti]) ? iolt_pkg::stat_t'(stat_rbits) : '0;

  iolt_stat_upd u_stat_upd (
    .old_stat (stat_old),
    .elapsed  (elapsed),
    .new_stat (stat_new)
  );

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    load       = 1'b0;
    stat_we    = 1'b0;
    case (state)
      iolt_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          state_next = iolt_pkg::ST_UPDATE;
        end
      end
      iolt_pkg::ST_UPDATE: begin
        if (!o_valid || rsp.ready) begin
          load       = 1'b1;
          stat_we    = l_valid && (l_func == iolt_pkg::FUNC_END);
          state_next = iolt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = iolt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= iolt_pkg::ST_IDLE;
      occ      <= '0;
      depth    <= '0;
      overflow <= '0;
      stat_vld <= '0;
      o_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        occ   <= occ_next;
        depth <= depth_next;
        if ((req.func == iolt_pkg::FUNC_BEGIN) && in_valid && full && !(&overflow)) begin
          overflow <= overflow + 1'b1;
        end
      end
      if (stat_we) begin
        stat_vld[l_ti] <= 1'b1;
      end
      if (load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      l_func     <= req.func;
      l_type     <= req.op_type;
      l_valid    <= in_valid;
      l_push     <= push;
      l_tok_slot <= push ? 4'(depth) : 4'd0;
      l_now      <= req.now_ns;
      elapsed    <= (req.now_ns > req.start_stamp) ? req.now_ns - req.start_stamp : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_token_type       <= (l_func == iolt_pkg::FUNC_BEGIN && l_valid) ? l_type : '0;
      o_token_slot_valid <= l_push;
      o_token_slot       <= l_tok_slot;
      if (depth == '0) begin
        o_current_type     <= '0;
        o_current_start_ns <= '0;
      end else if (l_push) begin
        o_current_type     <= l_type;
        o_current_start_ns <= l_now;
      end else begin
        o_current_type     <= slot_rdata.kind;
        o_current_start_ns <= slot_rdata.stamp;
      end
      o_stack_depth    <= 5'(depth);
      o_overflow_count <= overflow;
      if (!l_valid) begin
        o_stat_count    <= '0;
        o_stat_total_ns <= '0;
        o_stat_max_ns   <= '0;
      end else if (l_func == iolt_pkg::FUNC_END) begin
        o_stat_count    <= stat_new.count;
        o_stat_total_ns <= stat_new.sum_ns;
        o_stat_max_ns   <= stat_new.max_ns;
      end else begin
        o_stat_count    <= stat_old.count;
        o_stat_total_ns <= stat_old.sum_ns;
        o_stat_max_ns   <= stat_old.max_ns;
      end
    end
  end

  assign req.ready            = req_ready;
  assign rsp.valid            = o_valid;
  assign rsp.token_type       = o_token_type;
  assign rsp.token_slot_valid = o_token_slot_valid;
  assign rsp.token_slot       = o_token_slot;
  assign rsp.current_type     = o_current_type;
  assign rsp.current_start_ns = o_current_start_ns;
  assign rsp.stack_depth      = o_stack_depth;
  assign rsp.overflow_count   = o_overflow_count;
  assign rsp.stat_count       = o_stat_count;
  assign rsp.stat_total_ns    = o_stat_total_ns;
  assign rsp.stat_max_ns      = o_stat_max_ns;

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    32'(depth) <= iolt_pkg::STACK_DEPTH)
    else $error("stack depth out of range");

  a_no_slot_above_top: assert property (@(posedge clk) disable iff (rst)
    (occ >> depth) == '0)
    else $error("occupied slot above stack top");

  a_top_occupied: assert property (@(posedge clk) disable iff (rst)
    depth != '0 |-> ((occ >> (depth - 1'b1)) & iolt_pkg::STACK_DEPTH'(1)) != '0)
    else $error("stack top is a hole after trim");

  a_accept_goes_update: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == iolt_pkg::ST_UPDATE && !req_ready)
    else $error("request taken while update pending");

  a_stat_write_after_accept: assert property (@(posedge clk) disable iff (rst)
    stat_we |-> state == iolt_pkg::ST_UPDATE && !accept)
    else $error("statistics write overlaps a read");

endmodule
